FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the radix digit converter.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons in the next cycle");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/b2rd_pkg.sv
// Package of the radix digit converter: widths, register codes, sequencer
// states, divider interface structs and the digit to ASCII mapping. No dependencies.
package b2rd_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = $clog2(VALUE_BITS);
   localparam int RADIX_BITS  = 6;
   localparam int CHAR_BITS   = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd62;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 7'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 7'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 7'h7A;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [RADIX_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
      logic [RADIX_BITS-1:0] remainder;
   } div_rsp_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d <= 6'd9) begin
         c = CHAR_ZERO + {1'b0, d};
      end else if (d <= 6'd35) begin
         c = CHAR_UPPER_A + {1'b0, 6'(d - 6'd10)};
      end else begin
         c = CHAR_LOWER_A + {1'b0, 6'(d - 6'd36)};
      end
      return c;
   endfunction

endpackage

FILE: rtl/b2rd_divider.sv
// Restoring divider: VALUE_BITS-bit dividend by a 6-bit divisor, one
// quotient bit per cycle. Depends on b2rd_pkg.
module b2rd_divider
   import b2rd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam logic [IDX_BITS-1:0] LAST_STEP = IDX_BITS'(VALUE_BITS - 1);

   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] div_ff, div_in;
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [RADIX_BITS:0]   trial;
   logic [RADIX_BITS:0]   diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (busy_ff) begin
         // shift in one quotient bit, keep the partial remainder below the divisor
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: rtl/binary_to_radix_digits_unit.sv
// Top level of the radix digit converter: sequencer, digit buffer and output register.
// Depends on b2rd_pkg, b2rd_divider and assert_macros.svh.
//
// Converts an unsigned 32-bit request value to ASCII digits in the radix held in the
// csr register (reset 16; 0 and 1 act as 2, 63 acts as 62), most significant digit
// first, one response per digit, with rsp_last_digit set on the final digit. A zero
// value gives the single digit '0'. Each digit takes one pass of the shared restoring
// divider, and the digits are then replayed from the digit buffer through the read and
// load states. req_stall stays high until the last digit has been placed in the output
// register; that digit may still wait there while the next request is taken.
`include "assert_macros.svh"

module binary_to_radix_digits_unit
   import b2rd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_value,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last_digit,

   input  logic                  csr_wr_en,
   input  logic [RADIX_BITS-1:0] csr_wr_data
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(VALUE_BITS - 1);

   state_type state_ff, state_in;

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [RADIX_BITS-1:0] radix_sat;
   logic [IDX_BITS-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_BITS-1:0]   rd_ptr_ff, rd_ptr_in;

   logic [RADIX_BITS-1:0] digit_mem [VALUE_BITS];
   logic [RADIX_BITS-1:0] rd_digit_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_digit_char_ff, rsp_digit_char_in;
   logic                  rsp_last_digit_ff, rsp_last_digit_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  mem_wr;
   logic                  mem_rd;
   logic                  load;
   logic                  last_div;

   logic                  next_digit;
   logic                  last_load;
   logic                  digit_legal;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   b2rd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // radix register and its saturated use
   always_comb begin
      radix_in = csr_wr_en ? csr_wr_data : radix_ff;
      if (radix_ff < RADIX_MIN) begin
         radix_sat = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         radix_sat = RADIX_MAX;
      end else begin
         radix_sat = radix_ff;
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_div   = (div_rsp.quotient == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done && last_div) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = (rd_ptr_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall        = 1'b1;
      div_req.start    = 1'b0;
      div_req.dividend = div_rsp.quotient;
      div_req.divisor  = radix_sat;
      mem_wr           = 1'b0;
      mem_rd           = 1'b0;
      load             = 1'b0;
      wr_idx_in        = wr_idx_ff;
      rd_ptr_in        = rd_ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall        = 1'b0;
            div_req.start    = req_valid;
            div_req.dividend = VALUE_BITS'(req_value);
            wr_idx_in        = '0;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               mem_wr = 1'b1;
               if (last_div) begin
                  rd_ptr_in = wr_idx_ff;
               end else begin
                  // divide the quotient again for the next digit
                  div_req.start = 1'b1;
                  wr_idx_in     = wr_idx_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            mem_rd = 1'b1;
         end
         ST_LOAD: begin
            if (out_free) begin
               load = 1'b1;
               if (rd_ptr_ff != '0) begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // output register: drop on take, fill on load
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_digit_char_in = rsp_digit_char_ff;
      rsp_last_digit_in = rsp_last_digit_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in      = 1'b1;
         rsp_digit_char_in = digit_to_ascii(rd_digit_ff);
         rsp_last_digit_in = (rd_ptr_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         wr_idx_ff    <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_idx_ff    <= wr_idx_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_digit_char_ff <= rsp_digit_char_in;
      rsp_last_digit_ff <= rsp_last_digit_in;
   end

   // digit buffer, least significant digit at index zero
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         digit_mem[wr_idx_ff] <= div_rsp.remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_digit_ff <= digit_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_digit_char_ff;
   assign rsp_last_digit = rsp_last_digit_ff;

   assign next_digit  = div_rsp.done && !last_div;
   assign last_load   = load && (rd_ptr_ff == '0);
   assign digit_legal =
      (rsp_digit_char_ff >= CHAR_ZERO && rsp_digit_char_ff <= CHAR_NINE) ||
      (rsp_digit_char_ff >= CHAR_UPPER_A && rsp_digit_char_ff <= CHAR_UPPER_Z) ||
      (rsp_digit_char_ff >= CHAR_LOWER_A && rsp_digit_char_ff <= CHAR_LOWER_Z);

   `ASSERT_IMPLIES(a_done_in_divide, clock, reset, div_rsp.done, state_ff == ST_DIVIDE)
   `ASSERT_IMPLIES(a_no_buffer_overrun, clock, reset, next_digit, wr_idx_ff != LAST_IDX)
   `ASSERT_IMPLIES(a_digit_char_legal, clock, reset, rsp_valid_ff, digit_legal)
   `ASSERT_NEXT(a_last_load_frees_input, clock, reset, last_load, !req_stall && rsp_last_digit)

endmodule

FILE: tb/radix_digits_checker.sv
// Checker for the radix digit converter: watches the request, response and csr ports,
// predicts the digit string of every accepted request and compares each response.
// Depends on b2rd_pkg for widths, radix limits and character constants.
module radix_digits_checker
   import b2rd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [31:0]           req_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CHAR_BITS-1:0]  rsp_digit_char,
   input  logic                  rsp_last_digit,
   input  logic                  csr_wr_en,
   input  logic [RADIX_BITS-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    digits_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [CHAR_BITS-1:0] code;
      logic                 is_last;
   } digit_item_type;

   digit_item_type        expected_digits[$];
   logic [RADIX_BITS-1:0] radix_reg = RADIX_RESET;
   int                    errors = 0;
   int                    pending = 0;

   assign fail_count     = errors;
   assign digits_pending = pending;

   function automatic void queue_radix_digits(input logic [31:0] value);
      logic [RADIX_BITS-1:0] base;
      logic [RADIX_BITS-1:0] rem [VALUE_BITS];
      logic [31:0]           rest;
      int                    count;
      int                    k;
      digit_item_type        item;
      // out-of-range radix settings saturate to the nearest legal base
      base = (radix_reg < RADIX_MIN) ? RADIX_MIN :
             (radix_reg > RADIX_MAX) ? RADIX_MAX : radix_reg;
      // only the low VALUE_BITS bits take part
      rest  = 32'(VALUE_BITS'(value));
      count = 0;
      do begin
         rem[count] = RADIX_BITS'(rest % base);
         rest       = rest / base;
         count++;
      end while (rest != 0);
      for (k = count - 1; k >= 0; k--) begin
         if (rem[k] < 10) begin
            item.code = CHAR_ZERO + CHAR_BITS'(rem[k]);
         end else if (rem[k] < 36) begin
            item.code = CHAR_UPPER_A + CHAR_BITS'(rem[k] - 6'd10);
         end else begin
            item.code = CHAR_LOWER_A + CHAR_BITS'(rem[k] - 6'd36);
         end
         item.is_last = (k == 0);
         expected_digits.push_back(item);
      end
   endfunction

   always @(posedge clock) begin : check_responses
      digit_item_type want;
      if (reset) begin
         radix_reg <= RADIX_RESET;
         expected_digits.delete();
      end else begin
         if (csr_wr_en) begin
            radix_reg <= csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            queue_radix_digits(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected digit: got char %02h last %0b",
                        $time, rsp_digit_char, rsp_last_digit);
               errors++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit_char !== want.code || rsp_last_digit !== want.is_last) begin
                  $display("%0t: digit mismatch: expected char %02h last %0b, got char %02h last %0b",
                           $time, want.code, want.is_last, rsp_digit_char, rsp_last_digit);
                  errors++;
               end
            end
         end
      end
      pending <= expected_digits.size();
   end

endmodule

FILE: tb/tb_binary_to_radix_digits_unit.sv
// Testbench top for binary_to_radix_digits_unit: clock, reset, request and csr stimulus,
// random response stalls and the final verdict. Depends on b2rd_pkg and radix_digits_checker.
module tb_binary_to_radix_digits_unit
   import b2rd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [31:0]           req_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CHAR_BITS-1:0]  rsp_digit_char;
   logic                  rsp_last_digit;
   logic                  csr_wr_en;
   logic [RADIX_BITS-1:0] csr_wr_data;
   int                    fail_count;
   int                    digits_pending;
   int                    gap_pct = 0;
   int                    stall_pct = 0;

   binary_to_radix_digits_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   radix_digits_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .digits_pending (digits_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Present one request at a falling edge and hold it until accepted.
   task automatic send_value(input logic [31:0] value);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         req_value <= $urandom();
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold off requests until every digit has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (digits_pending != 0);
   endtask

   task automatic write_radix(input logic [RADIX_BITS-1:0] radix);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= radix;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] pick_operand(input logic [RADIX_BITS-1:0] radix);
      logic [63:0] power;
      int unsigned base;
      int unsigned k;
      base  = (radix < RADIX_MIN) ? 2 : (radix > RADIX_MAX) ? 62 : radix;
      power = 1;
      k     = $urandom_range(31, 1);
      case ($urandom_range(7))
         0: return 32'd0;
         1: return $urandom_range(base - 1);
         2: return $urandom_range(4095);
         3: return 32'hFFFF_FFFF - $urandom_range(3);
         4: begin
            // land on a digit-count boundary: a power of base up to base**k, or one below it
            repeat (k) if (power * base <= 64'hFFFF_FFFF) power = power * base;
            return 32'(power - $urandom_range(1));
         end
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [RADIX_BITS-1:0] radix;
      int                    ph;
      int                    n;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_value   = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset radix is sixteen
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd15);
      send_value(32'd16);
      send_value(32'd255);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
      send_value(32'h1234_5678);

      // top of the range: every letter class
      write_radix(RADIX_MAX);
      send_value(32'd35);
      send_value(32'd36);
      send_value(32'd61);
      send_value(32'd62);
      send_value(32'd3843);
      send_value(32'hFFFF_FFFF);

      // radix one saturates to binary: longest digit strings
      write_radix(6'd1);
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
      send_value(32'h8000_0001);

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       radix = RADIX_MIN;
            1:       radix = RADIX_MAX;
            2:       radix = 6'd63;
            3:       radix = 6'd0;
            4:       radix = 6'd10;
            default: radix = RADIX_BITS'($urandom_range(61, 3));
         endcase
         write_radix(radix);
         case (ph % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 71;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 71;
            end
            default: begin
               gap_pct   = 34;
               stall_pct = 34;
            end
         endcase
         for (n = 0; n < 49; n++) begin
            if (n == 24) begin
               wait_drained();
            end
            send_value(pick_operand(radix));
         end
      end

      wait_drained();
      // give a stray extra digit time to show up
      repeat (1200) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
